[rtl/sha_pkg.sv]
// ---------------------------------------------------------------------------
// sha_pkg
// shared types, round constants and helper function for the sha-256 hasher
// ---------------------------------------------------------------------------
package sha_pkg;

    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = 2;

    // one classified input word passed from the front end to the engine
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       eom;
    } item_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_SLOT   = 6'd56;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

[rtl/sha256_byte_stream_hasher_unit.sv]
// ---------------------------------------------------------------------------
// sha256_byte_stream_hasher_unit
// sha-256 over a byte stream: queue front end and iterative compression engine
// ---------------------------------------------------------------------------
// a byte word is packed into the window while idle; a full block then runs the
// 64 rounds on the single round unit plus the chaining add
// message end: padding and length bytes and one or two compressions,
// then eight digest words, one a cycle while not stalled
// reset clears chaining words to the initial hash, bit count and slot to zero
module sha256_byte_stream_hasher_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  msg_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    input  logic        in_valid,
    output logic        in_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word,
    output logic        out_valid,
    input  logic        out_stall
);
    import sha_pkg::*;

    item_t q_item;
    logic  q_valid, q_take;

    sha_queue u_queue (
        .clk, .rst_n, .msg_byte, .has_byte, .end_of_message,
        .valid(in_valid), .stall(in_stall),
        .q_item, .q_valid, .q_take
    );

    sha_engine u_engine (
        .clk, .rst_n, .q_item, .q_valid, .q_take,
        .digest_word, .word_index, .last_word,
        .valid(out_valid), .stall(out_stall)
    );

endmodule

[rtl/sha_queue.sv]
// ---------------------------------------------------------------------------
// sha_queue
// front end: accepts input words, drops idle words, buffers the rest
// ---------------------------------------------------------------------------
module sha_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [7:0]     msg_byte,
    input  logic           has_byte,
    input  logic           end_of_message,
    input  logic           valid,
    output logic           stall,
    output sha_pkg::item_t q_item,
    output logic           q_valid,
    input  logic           q_take
);
    import sha_pkg::*;

    item_t                mem [QueueDepth];
    logic [QueuePtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QueuePtrW:0]   count_reg, count_next;
    logic                 push, pop;

    assign stall   = (count_reg == QueuePtrW'(0) + (QueuePtrW+1)'(QueueDepth));
    assign q_valid = (count_reg != '0);
    assign pop     = q_valid && q_take;
    // idle words carry nothing, so they are consumed here
    assign push    = valid && !stall && (has_byte || end_of_message);
    assign q_item  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (!push && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= '{data: msg_byte, has_byte: has_byte, eom: end_of_message};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QueuePtrW+1)'(QueueDepth))
        else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        stall |-> !push)
        else $error("push into full queue");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance");

endmodule

[rtl/sha_engine.sv]
// ---------------------------------------------------------------------------
// sha_engine
// back end: packs bytes, pads, runs the 64-round compression and emits digest
// ---------------------------------------------------------------------------
module sha_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  sha_pkg::item_t q_item,
    input  logic           q_valid,
    output logic           q_take,
    output logic [31:0]    digest_word,
    output logic [2:0]     word_index,
    output logic           last_word,
    output logic           valid,
    input  logic           stall
);
    import sha_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_COMP  = 6'b000010,
        S_ADD   = 6'b000100,
        S_PAD   = 6'b001000,
        S_LEN   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t       state_reg;
    logic [31:0]  chain_reg [8];
    logic [31:0]  win_reg   [16];
    logic [31:0]  var_reg   [8];
    logic [63:0]  bits_reg;
    logic [5:0]   slot_reg;
    logic [5:0]   round_reg;
    logic [2:0]   len_idx_reg;
    logic         fin_reg;      // padding in progress for a message end
    logic         lendone_reg;  // length bytes written, last compression running
    logic         mark_reg;     // 0x80 still owed after a final data byte
    logic [2:0]   out_idx_reg;

    // byte into the packing window
    logic [7:0]   in_b;
    logic         do_put;
    logic [31:0]  w_new, t1, t2, wi, g0, g1, s1, s0, ch, mj;
    logic [31:0]  w15, w2;

    assign w15 = win_reg[1];
    assign w2  = win_reg[14];
    assign g0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    assign g1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    // window shifts each round, entry 0 is the current schedule word
    assign w_new = win_reg[0] + g0 + win_reg[9] + g1;
    assign wi  = win_reg[0];
    assign s1  = rotr(var_reg[4], 6) ^ rotr(var_reg[4], 11) ^ rotr(var_reg[4], 25);
    assign ch  = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
    assign t1  = var_reg[7] + s1 + ch + ROUND_K[round_reg] + wi;
    assign s0  = rotr(var_reg[0], 2) ^ rotr(var_reg[0], 13) ^ rotr(var_reg[0], 22);
    assign mj  = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
               ^ (var_reg[1] & var_reg[2]);
    assign t2  = s0 + mj;

    assign q_take = (state_reg == S_IDLE);

    always_comb
    begin
        do_put = 1'b0;
        in_b   = 8'h00;
        case (state_reg)
            S_IDLE:
            begin
                do_put = q_valid;
                in_b   = q_item.has_byte ? q_item.data : PAD_BYTE;
            end
            S_PAD:
            begin
                do_put = 1'b1;
                in_b   = mark_reg ? PAD_BYTE : 8'h00;
            end
            S_LEN:
            begin
                do_put = 1'b1;
                in_b   = bits_reg[8*(7-len_idx_reg) +: 8];
            end
            default: ;
        endcase
    end

    assign valid       = (state_reg == S_OUT);
    assign digest_word = chain_reg[out_idx_reg];
    assign word_index  = out_idx_reg;
    assign last_word   = (out_idx_reg == 3'd7);

    always_ff @(posedge clk)
    begin
        if (do_put)
        begin
            if (slot_reg[1:0] == 2'd0)
                win_reg[slot_reg[5:2]] <= {in_b, 24'h0};
            else
                win_reg[slot_reg[5:2]][8*(3-slot_reg[1:0]) +: 8] <= in_b;
        end
        if (state_reg == S_COMP)
        begin
            for (int i = 0; i < 15; i++)
                win_reg[i] <= win_reg[i+1];
            win_reg[15] <= w_new;
            var_reg[0] <= t1 + t2;
            var_reg[1] <= var_reg[0];
            var_reg[2] <= var_reg[1];
            var_reg[3] <= var_reg[2];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[5] <= var_reg[4];
            var_reg[6] <= var_reg[5];
            var_reg[7] <= var_reg[6];
        end
        if (do_put && slot_reg == 6'd63)
            for (int i = 0; i < 8; i++)
                var_reg[i] <= chain_reg[i];
    end

    // entering compression: the block is complete after this byte
    logic enter_comp;
    assign enter_comp = do_put && slot_reg == 6'd63;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= START_HASH[i];
            bits_reg    <= '0;
            slot_reg    <= '0;
            round_reg   <= '0;
            len_idx_reg <= '0;
            fin_reg     <= 1'b0;
            lendone_reg <= 1'b0;
            mark_reg    <= 1'b0;
            out_idx_reg <= '0;
        end
        else
        begin
            if (do_put)
                slot_reg <= slot_reg + 1'b1;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_item.has_byte)
                            bits_reg <= bits_reg + 64'd8;
                        if (q_item.has_byte && !q_item.eom)
                        begin
                            if (enter_comp)
                            begin
                                round_reg <= '0;
                                state_reg <= S_COMP;
                            end
                        end
                        else if (q_item.has_byte)
                        begin
                            // byte now, 0x80 next via pad path
                            fin_reg   <= 1'b1;
                            mark_reg  <= 1'b1;
                            if (enter_comp)
                            begin
                                round_reg <= '0;
                                state_reg <= S_COMP;
                            end
                            else
                                state_reg <= S_PAD;
                        end
                        else
                        begin
                            // 0x80 already written this cycle
                            fin_reg <= 1'b1;
                            if (enter_comp)
                            begin
                                round_reg <= '0;
                                state_reg <= S_COMP;
                            end
                            else
                                state_reg <= (slot_reg + 1'b1 == LEN_SLOT) ? S_LEN : S_PAD;
                        end
                    end
                end
                S_PAD:
                begin
                    mark_reg <= 1'b0;
                    if (enter_comp)
                    begin
                        round_reg <= '0;
                        state_reg <= S_COMP;
                    end
                    else if (slot_reg + 1'b1 == LEN_SLOT)
                        state_reg <= S_LEN;
                end
                S_LEN:
                begin
                    len_idx_reg <= len_idx_reg + 1'b1;
                    if (enter_comp)
                    begin
                        lendone_reg <= 1'b1;
                        round_reg   <= '0;
                        state_reg   <= S_COMP;
                    end
                end
                S_COMP:
                begin
                    round_reg <= round_reg + 1'b1;
                    if (round_reg == 6'd63)
                        state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                        chain_reg[i] <= chain_reg[i] + var_reg[i];
                    if (lendone_reg)
                        state_reg <= S_OUT;
                    else if (fin_reg)
                        state_reg <= (slot_reg == LEN_SLOT) ? S_LEN : S_PAD;
                    else
                        state_reg <= S_IDLE;
                end
                S_OUT:
                begin
                    if (!stall)
                    begin
                        out_idx_reg <= out_idx_reg + 1'b1;
                        if (out_idx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                                chain_reg[i] <= START_HASH[i];
                            bits_reg    <= '0;
                            slot_reg    <= '0;
                            fin_reg     <= 1'b0;
                            lendone_reg <= 1'b0;
                            state_reg   <= S_IDLE;
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");
    a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> slot_reg == 6'd0)
        else $error("digest out with partial block");
    a_len_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LEN) |-> slot_reg[5:3] == 3'd7)
        else $error("length written outside last eight bytes");

endmodule
